/* rtl/core/tcc_pkg.sv */
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// tcc_pkg
// Shared widths and request/result types of the tetrahedron circumcentre block.
// -----------------------------------------------------------------------------
package tcc_pkg;

  localparam int CoordW      = 16;  // input coordinate width, two's complement
  localparam int CenterW     = 32;  // output centre coordinate width
  localparam int FracBitsDef = 8;   // default fraction bits of the centre

  typedef struct packed {
    logic signed [CoordW-1:0] a_x;
    logic signed [CoordW-1:0] a_y;
    logic signed [CoordW-1:0] a_z;
    logic signed [CoordW-1:0] b_x;
    logic signed [CoordW-1:0] b_y;
    logic signed [CoordW-1:0] b_z;
    logic signed [CoordW-1:0] c_x;
    logic signed [CoordW-1:0] c_y;
    logic signed [CoordW-1:0] c_z;
    logic signed [CoordW-1:0] d_x;
    logic signed [CoordW-1:0] d_y;
    logic signed [CoordW-1:0] d_z;
  } tcc_in_t;

  typedef struct packed {
    logic signed [CenterW-1:0] center_x;
    logic signed [CenterW-1:0] center_y;
    logic signed [CenterW-1:0] center_z;
    logic                      degenerate;
    logic                      overflow;
  } tcc_out_t;

endpackage

/* rtl/core/tetrahedron_circumcenter_top.sv */
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// tetrahedron_circumcenter_top
// Circumsphere centre of four 3D points, fully pipelined, one request a cycle unless stalled.
// -----------------------------------------------------------------------------
// Takes one request (four points) per clock while not stalled and returns its
// circumsphere centre in order, in signed fixed point with FRAC_BITS fraction
// bits, truncated toward zero. The pipeline is the 34-stage restoring divider
// (one quotient bit per stage) behind six arithmetic stages and the output
// register. A zero determinant gives a zero centre with degenerate set; a
// centre outside the 32-bit range saturates and sets overflow. Each stage
// moves on when it is empty or the stage ahead moves, so bubbles collapse and
// requests are still taken while a result waits, until every stage is full.
// -----------------------------------------------------------------------------
module tetrahedron_circumcenter_top #(
  parameter int FRAC_BITS = tcc_pkg::FracBitsDef
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  tcc_pkg::tcc_in_t in_data_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output tcc_pkg::tcc_out_t out_data_o
);
  import tcc_pkg::*;

  // Widths of the intermediate values
  localparam int C    = CoordW;
  localparam int OW   = 2 * C + 3;          // twice the plane offset
  localparam int PW   = 2 * C + 2;          // product of two normal terms
  localparam int CFW  = 2 * C + 3;          // cofactor
  localparam int L    = (CFW + 1) / 2;      // low split of a cofactor
  localparam int DETW = 3 * C + 6;          // determinant
  localparam int ACCW = 4 * C + 8;          // cofactor row times offsets
  localparam int NW   = ACCW + FRAC_BITS;   // scaled numerator
  localparam int DW   = DETW + 1;           // denominator, twice det
  localparam int QB   = 34;                 // quotient bits, top two flag overflow
  localparam int RW   = (NW > DW + QB) ? NW : DW + QB;
  localparam int NDIV = QB;
  localparam int NST  = 6 + NDIV + 1;       // total register stages

  // Stage valid bits and per-stage enables
  logic [NST-1:0] vld_q;
  logic [NST:0]   en;

  always_comb begin
    en[NST] = !out_stall_i;
    for (int k = NST - 1; k >= 0; k--) begin
      en[k] = !vld_q[k] || en[k+1];
    end
  end

  assign in_stall_o = !en[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      for (int k = 0; k < NST; k++) begin
        if (en[k]) begin
          vld_q[k] <= (k == 0) ? in_valid_i : vld_q[(k == 0) ? 0 : k - 1];
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 1: plane normals a - p and coordinate squares
  // ---------------------------------------------------------------------------
  logic signed [C-1:0]   p     [4][3];
  logic signed [C:0]     n_q   [3][3];
  logic signed [2*C-1:0] sq_q  [4][3];

  always_comb begin
    p[0][0] = in_data_i.a_x; p[0][1] = in_data_i.a_y; p[0][2] = in_data_i.a_z;
    p[1][0] = in_data_i.b_x; p[1][1] = in_data_i.b_y; p[1][2] = in_data_i.b_z;
    p[2][0] = in_data_i.c_x; p[2][1] = in_data_i.c_y; p[2][2] = in_data_i.c_z;
    p[3][0] = in_data_i.d_x; p[3][1] = in_data_i.d_y; p[3][2] = in_data_i.d_z;
  end

  always_ff @(posedge clk_i) begin
    if (en[0] && in_valid_i) begin
      for (int i = 0; i < 4; i++) begin
        for (int j = 0; j < 3; j++) begin
          sq_q[i][j] <= (2*C)'(p[i][j]) * (2*C)'(p[i][j]);
        end
      end
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          n_q[i][j] <= (C+1)'(p[0][j]) - (C+1)'(p[i+1][j]);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 2: offsets and the 2x2 minor products
  // ---------------------------------------------------------------------------
  logic signed [OW-1:0] off_q [3];
  logic signed [C:0]    n0_q2 [3];
  logic signed [PW-1:0] pa_q  [9];
  logic signed [PW-1:0] pb_q  [9];

  function automatic logic signed [PW-1:0] mulp(logic signed [C:0] x, logic signed [C:0] y);
    mulp = PW'(x) * PW'(y);
  endfunction

  always_ff @(posedge clk_i) begin
    if (en[1] && vld_q[0]) begin
      for (int i = 0; i < 3; i++) begin
        off_q[i] <= OW'(sq_q[0][0]) - OW'(sq_q[i+1][0])
                  + OW'(sq_q[0][1]) - OW'(sq_q[i+1][1])
                  + OW'(sq_q[0][2]) - OW'(sq_q[i+1][2]);
        n0_q2[i] <= n_q[0][i];
      end
      pa_q[0] <= mulp(n_q[1][1], n_q[2][2]); pb_q[0] <= mulp(n_q[1][2], n_q[2][1]);
      pa_q[1] <= mulp(n_q[0][2], n_q[2][1]); pb_q[1] <= mulp(n_q[0][1], n_q[2][2]);
      pa_q[2] <= mulp(n_q[0][1], n_q[1][2]); pb_q[2] <= mulp(n_q[0][2], n_q[1][1]);
      pa_q[3] <= mulp(n_q[1][2], n_q[2][0]); pb_q[3] <= mulp(n_q[1][0], n_q[2][2]);
      pa_q[4] <= mulp(n_q[0][0], n_q[2][2]); pb_q[4] <= mulp(n_q[0][2], n_q[2][0]);
      pa_q[5] <= mulp(n_q[0][2], n_q[1][0]); pb_q[5] <= mulp(n_q[0][0], n_q[1][2]);
      pa_q[6] <= mulp(n_q[1][0], n_q[2][1]); pb_q[6] <= mulp(n_q[1][1], n_q[2][0]);
      pa_q[7] <= mulp(n_q[0][1], n_q[2][0]); pb_q[7] <= mulp(n_q[0][0], n_q[2][1]);
      pa_q[8] <= mulp(n_q[0][0], n_q[1][1]); pb_q[8] <= mulp(n_q[0][1], n_q[1][0]);
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 3: cofactors
  // ---------------------------------------------------------------------------
  logic signed [CFW-1:0] cf_q   [9];
  logic signed [OW-1:0]  off_q3 [3];
  logic signed [C:0]     n0_q3  [3];

  always_ff @(posedge clk_i) begin
    if (en[2] && vld_q[1]) begin
      for (int m = 0; m < 9; m++) begin
        cf_q[m] <= CFW'(pa_q[m]) - CFW'(pb_q[m]);
      end
      off_q3 <= off_q;
      n0_q3  <= n0_q2;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 4: partial products, cofactor split into low and high halves
  // ---------------------------------------------------------------------------
  logic signed [DETW-1:0] pdl_q [3];
  logic signed [DETW-1:0] pdh_q [3];
  logic signed [ACCW-1:0] pal_q [9];
  logic signed [ACCW-1:0] pah_q [9];

  always_ff @(posedge clk_i) begin
    if (en[3] && vld_q[2]) begin
      for (int k = 0; k < 3; k++) begin
        pdl_q[k] <= DETW'(n0_q3[k]) * DETW'($signed({1'b0, cf_q[k*3][L-1:0]}));
        pdh_q[k] <= DETW'(n0_q3[k]) * DETW'($signed(cf_q[k*3][CFW-1:L]));
      end
      for (int m = 0; m < 9; m++) begin
        pal_q[m] <= ACCW'(off_q3[m%3]) * ACCW'($signed({1'b0, cf_q[m][L-1:0]}));
        pah_q[m] <= ACCW'(off_q3[m%3]) * ACCW'($signed(cf_q[m][CFW-1:L]));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 5: determinant and scaled numerators
  // ---------------------------------------------------------------------------
  logic signed [DETW-1:0] det_d;
  logic signed [ACCW-1:0] acc_d [3];
  logic signed [DW-1:0]   den_q;
  logic signed [NW-1:0]   num_q [3];

  always_comb begin
    det_d = '0;
    for (int k = 0; k < 3; k++) begin
      det_d = det_d + (pdh_q[k] <<< L) + pdl_q[k];
    end
    for (int i = 0; i < 3; i++) begin
      acc_d[i] = '0;
      for (int k = 0; k < 3; k++) begin
        acc_d[i] = acc_d[i] + (pah_q[i*3+k] <<< L) + pal_q[i*3+k];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[4] && vld_q[3]) begin
      den_q <= DW'(det_d) <<< 1;
      for (int i = 0; i < 3; i++) begin
        num_q[i] <= NW'(acc_d[i]) <<< FRAC_BITS;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 6: magnitudes and result signs
  // ---------------------------------------------------------------------------
  logic [RW-1:0] mn_q [3];
  logic [RW-1:0] md_q;
  logic [2:0]    ng_q;
  logic          dg_q;

  always_ff @(posedge clk_i) begin
    if (en[5] && vld_q[4]) begin
      for (int i = 0; i < 3; i++) begin
        mn_q[i] <= RW'(num_q[i][NW-1] ? $unsigned(-num_q[i]) : $unsigned(num_q[i]));
        ng_q[i] <= num_q[i][NW-1] ^ den_q[DW-1];
      end
      md_q <= RW'(den_q[DW-1] ? $unsigned(-den_q) : $unsigned(den_q));
      dg_q <= (den_q == '0);
    end
  end

  // ---------------------------------------------------------------------------
  // Divider: one restoring step per stage, most significant quotient bit first
  // ---------------------------------------------------------------------------
  logic [RW-1:0] rr_q [NDIV][3];
  logic [QB-1:0] qq_q [NDIV][3];
  logic [RW-1:0] dd_q [NDIV];
  logic [2:0]    dn_q [NDIV];
  logic          dz_q [NDIV];

  for (genvar k = 0; k < NDIV; k++) begin : g_div
    localparam int S = QB - 1 - k;
    logic [RW-1:0] r_in [3];
    logic [QB-1:0] q_in [3];
    logic [RW-1:0] d_in;
    logic [2:0]    n_in;
    logic          z_in;
    logic [RW-1:0] dsh;

    if (k == 0) begin : g_first
      assign r_in = mn_q;
      assign q_in = '{default: '0};
      assign d_in = md_q;
      assign n_in = ng_q;
      assign z_in = dg_q;
    end else begin : g_next
      assign r_in = rr_q[k-1];
      assign q_in = qq_q[k-1];
      assign d_in = dd_q[k-1];
      assign n_in = dn_q[k-1];
      assign z_in = dz_q[k-1];
    end

    assign dsh = d_in << S;

    always_ff @(posedge clk_i) begin
      if (en[6+k] && vld_q[5+k]) begin
        for (int i = 0; i < 3; i++) begin
          if (r_in[i] >= dsh) begin
            rr_q[k][i] <= r_in[i] - dsh;
            qq_q[k][i] <= q_in[i] | (QB'(1) << S);
          end else begin
            rr_q[k][i] <= r_in[i];
            qq_q[k][i] <= q_in[i];
          end
        end
        dd_q[k] <= d_in;
        dn_q[k] <= n_in;
        dz_q[k] <= z_in;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Output stage: sign, saturation and the degenerate case
  // ---------------------------------------------------------------------------
  logic [CenterW-1:0] cv_d [3];
  logic [2:0]         sat_d;
  tcc_out_t           out_d;
  tcc_out_t           out_q;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      logic [QB-1:0]      q;
      logic               high;
      q    = qq_q[NDIV-1][i];
      high = (q[QB-1:CenterW] != '0);
      if (dn_q[NDIV-1][i]) begin
        sat_d[i] = high || (q[CenterW-1:0] > {1'b1, {(CenterW-1){1'b0}}});
        cv_d[i]  = sat_d[i] ? {1'b1, {(CenterW-1){1'b0}}} : -q[CenterW-1:0];
      end else begin
        sat_d[i] = high || q[CenterW-1];
        cv_d[i]  = sat_d[i] ? {1'b0, {(CenterW-1){1'b1}}} : q[CenterW-1:0];
      end
    end
    if (dz_q[NDIV-1]) begin
      out_d = '{center_x: '0, center_y: '0, center_z: '0, degenerate: 1'b1,
                overflow: 1'b0};
    end else begin
      out_d = '{center_x: $signed(cv_d[0]), center_y: $signed(cv_d[1]),
                center_z: $signed(cv_d[2]), degenerate: 1'b0,
                overflow: (sat_d != '0)};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[NST-1] && vld_q[NST-2]) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = vld_q[NST-1];
  assign out_data_o  = out_q;

endmodule

/* rtl/core/tcc_checker.sv */
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// tcc_checker
// Port-level checks of the tetrahedron circumcentre block, bound to the top.
// -----------------------------------------------------------------------------
module tcc_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_stall_o,
  input logic              out_valid_o,
  input logic              out_stall_i,
  input tcc_pkg::tcc_out_t out_data_o
);
  import tcc_pkg::*;

  // held result stays put
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("result changed while stalled");

  // empty output means the pipe can take a request
  a_no_stall_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> !in_stall_o)
    else $error("input stalled with empty output");

  // degenerate result carries a zero centre and no overflow
  a_degen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.degenerate |->
      out_data_o.center_x == '0 && out_data_o.center_y == '0 &&
      out_data_o.center_z == '0 && !out_data_o.overflow)
    else $error("degenerate result not clean");

  // overflow only with some coordinate at a range limit
  a_ovf: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.overflow |->
      out_data_o.center_x == 32'h7FFFFFFF || out_data_o.center_x == 32'h80000000 ||
      out_data_o.center_y == 32'h7FFFFFFF || out_data_o.center_y == 32'h80000000 ||
      out_data_o.center_z == 32'h7FFFFFFF || out_data_o.center_z == 32'h80000000)
    else $error("overflow without saturated coordinate");

endmodule

bind tetrahedron_circumcenter_top tcc_checker u_tcc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);
